>>> rtl/core/snx_pkg.sv
// simplex noise package: widths, fixed-point constants, pipeline control types
// and the gradient helper functions; depends on nothing
package snx_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CW = 32;
	localparam int IW = CW + 2 - FRAC_BITS;
	localparam int DW = FRAC_BITS + 8;
	localparam int SW = 2 * DW;
	localparam int TW = FRAC_BITS + DW + 2;
	localparam int AW = TW + 2;
	localparam int OW = 18;
	localparam int NSTG = 13;
	localparam int ST_CORNER = 7;
	localparam int G2SH = 32 - FRAC_BITS;

	localparam logic [30:0] F2_Q32 = 31'd1572067139;
	localparam logic [29:0] G2_Q32 = 30'd907633386;
	localparam longint G2F_L =
		(longint'(907633386) + (longint'(1) << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
	localparam logic [DW-1:0] G2F = DW'(G2F_L);
	localparam logic [DW-1:0] ONE = DW'(1) << FRAC_BITS;
	localparam logic [SW-1:0] HALF = SW'(1) << (2 * FRAC_BITS - 1);
	localparam int OUT_MAX = 131071;
	localparam int OUT_MIN = -131072;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_EVAL = 1'b1
	} op_t;

	typedef logic [NSTG:1] stage_vec_t;

	typedef struct packed {
		stage_vec_t en;
		stage_vec_t vld;
	} pipe_ctl_t;

	typedef struct packed {
		op_t              op;
		logic [7:0]       idx;
		logic [7:0]       val;
		logic [CW-1:0]    x;
		logic [CW-1:0]    z;
	} req_word_t;

	typedef struct packed {
		logic [DW-1:0] dx;
		logic [DW-1:0] dz;
		logic [7:0]    perm;
	} corner_in_t;

	typedef struct packed {
		logic                 eval;
		corner_in_t [2:0]     c;
	} front_out_t;

	// hash modulo 12 through a reciprocal multiply
	function automatic logic [3:0] mod12(input logic [7:0] h);
		logic [15:0] p;
		logic [7:0]  qm;
		logic [7:0]  r;
		p = 16'(h) * 16'd171;
		qm = {3'b000, p[15:11]} * 8'd12;
		r = h - qm;
		return r[3:0];
	endfunction

	function automatic logic signed [DW:0] grad_dot(input logic [3:0] g,
		input logic [DW-1:0] dx, input logic [DW-1:0] dz);
		logic signed [DW:0] ex;
		logic signed [DW:0] ez;
		logic signed [DW:0] res;
		ex = (DW+1)'($signed(dx));
		ez = (DW+1)'($signed(dz));
		case (g)
			4'd0: res = ex + ez;
			4'd1: res = ez - ex;
			4'd2: res = ex - ez;
			4'd3: res = -ex - ez;
			4'd4, 4'd6: res = ex;
			4'd5, 4'd7: res = -ex;
			4'd8, 4'd10: res = ez;
			4'd9, 4'd11: res = -ez;
			default: res = '0;
		endcase
		return res;
	endfunction

endpackage

>>> rtl/core/snx_if.sv
// valid/ready channel interfaces for the simplex noise block
// depends on snx_pkg
interface snx_in_if;
	logic                        valid;
	logic                        ready;
	snx_pkg::op_t                op;
	logic [7:0]                  table_index;
	logic [7:0]                  table_value;
	logic signed [snx_pkg::CW-1:0] coord_x;
	logic signed [snx_pkg::CW-1:0] coord_z;
	modport source(output valid, op, table_index, table_value, coord_x, coord_z,
		input ready);
	modport sink(input valid, op, table_index, table_value, coord_x, coord_z,
		output ready);
endinterface

interface snx_out_if;
	logic                          valid;
	logic                          ready;
	logic signed [snx_pkg::OW-1:0] noise_value;
	modport source(output valid, noise_value, input ready);
	modport sink(input valid, noise_value, output ready);
endinterface

>>> rtl/core/snx_perm_ram.sv
// 256 x 8 permutation table copy, one write port, one registered read port
// standalone, no dependencies
module snx_perm_ram (
	input  logic       clk,
	input  logic       we,
	input  logic [7:0] waddr,
	input  logic [7:0] wdata,
	input  logic       re,
	input  logic [7:0] raddr,
	output logic [7:0] rdata
);

	logic [7:0] mem [256];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/snx_front.sv
// front pipeline stages 1 to 6: skew, cell floor, unskew, triangle pick, hashing
// depends on snx_pkg and snx_perm_ram
module snx_front (
	input  logic                  clk,
	input  snx_pkg::pipe_ctl_t    ctl,
	input  snx_pkg::req_word_t    req_w,
	output snx_pkg::front_out_t   fo
);

	localparam int CW = snx_pkg::CW;
	localparam int IW = snx_pkg::IW;
	localparam int DW = snx_pkg::DW;
	localparam int F = snx_pkg::FRAC_BITS;
	localparam int PW = 2 * CW + 1;
	localparam int UW = IW + 1 + 31;

	function automatic logic signed [IW-1:0] cell_floor(input logic signed [CW:0] v);
		logic signed [CW:0] sh;
		logic               adj;
		sh = v >>> F;
		adj = (v[CW] || (v == '0)) && (v[F-1:0] == '0);
		return IW'(sh) - IW'(adj);
	endfunction

	// stage 1
	snx_pkg::op_t          op_s1;
	logic [7:0]            idx_s1, val_s1;
	logic signed [CW-1:0]  x_s1, z_s1;
	logic signed [CW:0]    sxz_s1;
	// stage 2
	snx_pkg::op_t          op_s2;
	logic [7:0]            idx_s2, val_s2;
	logic signed [CW-1:0]  x_s2, z_s2, d_s2;
	// stage 3
	snx_pkg::op_t          op_s3;
	logic [7:0]            idx_s3, val_s3;
	logic signed [IW-1:0]  i_s3, j_s3;
	logic [DW-1:0]         xl_s3, zl_s3;
	// stage 4
	snx_pkg::op_t          op_s4;
	logic [7:0]            idx_s4, val_s4, i8_s4, j8_s4;
	logic [DW-1:0]         xl_s4, zl_s4, t_s4;
	logic [7:0]            pj0_s4, pj1_s4;
	// stage 5
	snx_pkg::op_t          op_s5;
	logic [7:0]            idx_s5, val_s5, i8_s5, pj0_s5, pj1_s5;
	logic signed [DW-1:0]  dx0_s5, dz0_s5;
	// stage 6
	logic                  eval_s6;
	logic [DW-1:0]         dx0_s6, dz0_s6, dx1_s6, dz1_s6, dx2_s6, dz2_s6;
	logic [7:0]            h0_s6, h1_s6, h2_s6;

	logic signed [PW-1:0]  skew_prod;
	logic signed [CW:0]    vx, vz;
	logic signed [IW:0]    sij;
	logic signed [UW-1:0]  unsk;
	logic                  k;
	logic [7:0]            a0, a1, a2;
	logic                  we_a, we_b;

	assign skew_prod = $signed(PW'(sxz_s1)) * $signed(PW'({1'b0, snx_pkg::F2_Q32}));
	assign vx = (CW+1)'(x_s2) + (CW+1)'(d_s2);
	assign vz = (CW+1)'(z_s2) + (CW+1)'(d_s2);
	assign sij = (IW+1)'(i_s3) + (IW+1)'(j_s3);
	assign unsk = $signed(UW'(sij)) * $signed(UW'({1'b0, snx_pkg::G2_Q32}));
	assign k = dx0_s5 > dz0_s5;
	assign a0 = i8_s5 + pj0_s5;
	assign a1 = k ? (i8_s5 + 8'd1 + pj0_s5) : (i8_s5 + pj1_s5);
	assign a2 = i8_s5 + 8'd1 + pj1_s5;
	assign we_a = ctl.en[4] && ctl.vld[3] && (op_s3 == snx_pkg::OP_LOAD);
	assign we_b = ctl.en[6] && ctl.vld[5] && (op_s5 == snx_pkg::OP_LOAD);

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			op_s1 <= req_w.op;
			idx_s1 <= req_w.idx;
			val_s1 <= req_w.val;
			x_s1 <= $signed(req_w.x);
			z_s1 <= $signed(req_w.z);
			sxz_s1 <= (CW+1)'($signed(req_w.x)) + (CW+1)'($signed(req_w.z));
		end
		if (ctl.en[2]) begin
			op_s2 <= op_s1;
			idx_s2 <= idx_s1;
			val_s2 <= val_s1;
			x_s2 <= x_s1;
			z_s2 <= z_s1;
			d_s2 <= skew_prod[2*CW-1:CW];
		end
		if (ctl.en[3]) begin
			op_s3 <= op_s2;
			idx_s3 <= idx_s2;
			val_s3 <= val_s2;
			i_s3 <= cell_floor(vx);
			j_s3 <= cell_floor(vz);
			xl_s3 <= x_s2[DW-1:0];
			zl_s3 <= z_s2[DW-1:0];
		end
		if (ctl.en[4]) begin
			op_s4 <= op_s3;
			idx_s4 <= idx_s3;
			val_s4 <= val_s3;
			i8_s4 <= i_s3[7:0];
			j8_s4 <= j_s3[7:0];
			xl_s4 <= xl_s3;
			zl_s4 <= zl_s3;
			t_s4 <= unsk[snx_pkg::G2SH+DW-1:snx_pkg::G2SH];
		end
		if (ctl.en[5]) begin
			op_s5 <= op_s4;
			idx_s5 <= idx_s4;
			val_s5 <= val_s4;
			i8_s5 <= i8_s4;
			pj0_s5 <= pj0_s4;
			pj1_s5 <= pj1_s4;
			dx0_s5 <= xl_s4 - {i8_s4, {F{1'b0}}} + t_s4;
			dz0_s5 <= zl_s4 - {j8_s4, {F{1'b0}}} + t_s4;
		end
		if (ctl.en[6]) begin
			eval_s6 <= (op_s5 == snx_pkg::OP_EVAL);
			dx0_s6 <= dx0_s5;
			dz0_s6 <= dz0_s5;
			dx1_s6 <= dx0_s5 - (k ? snx_pkg::ONE : '0) + snx_pkg::G2F;
			dz1_s6 <= dz0_s5 - (k ? '0 : snx_pkg::ONE) + snx_pkg::G2F;
			dx2_s6 <= dx0_s5 - snx_pkg::ONE + (snx_pkg::G2F << 1);
			dz2_s6 <= dz0_s5 - snx_pkg::ONE + (snx_pkg::G2F << 1);
		end
	end

	// first lookup, row entries at j and j+1
	snx_perm_ram u_ram_j0 (.clk(clk), .we(we_a), .waddr(idx_s3), .wdata(val_s3),
		.re(ctl.en[4]), .raddr(j_s3[7:0]), .rdata(pj0_s4));
	snx_perm_ram u_ram_j1 (.clk(clk), .we(we_a), .waddr(idx_s3), .wdata(val_s3),
		.re(ctl.en[4]), .raddr(j_s3[7:0] + 8'd1), .rdata(pj1_s4));

	// second lookup, one copy per corner
	snx_perm_ram u_ram_h0 (.clk(clk), .we(we_b), .waddr(idx_s5), .wdata(val_s5),
		.re(ctl.en[6]), .raddr(a0), .rdata(h0_s6));
	snx_perm_ram u_ram_h1 (.clk(clk), .we(we_b), .waddr(idx_s5), .wdata(val_s5),
		.re(ctl.en[6]), .raddr(a1), .rdata(h1_s6));
	snx_perm_ram u_ram_h2 (.clk(clk), .we(we_b), .waddr(idx_s5), .wdata(val_s5),
		.re(ctl.en[6]), .raddr(a2), .rdata(h2_s6));

	assign fo.eval = eval_s6;
	assign fo.c[0] = '{dx: dx0_s6, dz: dz0_s6, perm: h0_s6};
	assign fo.c[1] = '{dx: dx1_s6, dz: dz1_s6, perm: h1_s6};
	assign fo.c[2] = '{dx: dx2_s6, dz: dz2_s6, perm: h2_s6};

endmodule

>>> rtl/core/snx_corner.sv
// per-corner stages 7 to 11: squares, falloff, falloff^4, times gradient dot
// depends on snx_pkg
module snx_corner (
	input  logic                          clk,
	input  snx_pkg::pipe_ctl_t            ctl,
	input  snx_pkg::corner_in_t           ci,
	output logic signed [snx_pkg::TW-1:0] term
);

	localparam int F = snx_pkg::FRAC_BITS;
	localparam int DW = snx_pkg::DW;
	localparam int SW = snx_pkg::SW;
	localparam int TW = snx_pkg::TW;

	logic signed [SW-1:0] sqx_s7, sqz_s7;
	logic signed [DW:0]   dot_s7, dot_s8, dot_s9, dot_s10;
	logic                 pos_s8, pos_s9, pos_s10;
	logic [F-1:0]         r1_s8, r2_s9, r4_s10;
	logic signed [TW-1:0] term_s11;

	logic [SW-1:0]  ssum;
	logic [SW-1:0]  rfall;
	logic [2*F-1:0] sq1, sq2;

	assign ssum = sqx_s7 + sqz_s7;
	assign rfall = snx_pkg::HALF - ssum;
	assign sq1 = (2*F)'(r1_s8) * (2*F)'(r1_s8);
	assign sq2 = (2*F)'(r2_s9) * (2*F)'(r2_s9);

	always_ff @(posedge clk) begin
		if (ctl.en[7]) begin
			sqx_s7 <= SW'($signed(ci.dx)) * SW'($signed(ci.dx));
			sqz_s7 <= SW'($signed(ci.dz)) * SW'($signed(ci.dz));
			dot_s7 <= snx_pkg::grad_dot(snx_pkg::mod12(ci.perm), ci.dx, ci.dz);
		end
		if (ctl.en[8]) begin
			pos_s8 <= ssum <= snx_pkg::HALF;
			r1_s8 <= rfall[2*F-1:F];
			dot_s8 <= dot_s7;
		end
		if (ctl.en[9]) begin
			pos_s9 <= pos_s8;
			r2_s9 <= sq1[2*F-1:F];
			dot_s9 <= dot_s8;
		end
		if (ctl.en[10]) begin
			pos_s10 <= pos_s9;
			r4_s10 <= sq2[2*F-1:F];
			dot_s10 <= dot_s9;
		end
		if (ctl.en[11]) begin
			term_s11 <= pos_s10 ?
				$signed(TW'({1'b0, r4_s10})) * TW'(dot_s10) : '0;
		end
	end

	assign term = term_s11;

endmodule

>>> rtl/core/simplex_noise_2d.sv
// simplex noise top level: stage control, three corner lanes, sum and scaling
// depends on snx_pkg, snx_if, snx_front, snx_corner
//
// usage:
//   req carries one word per handshake: op 0 writes table_value into permutation
//   entry table_index, op 1 evaluates noise at the Q15.16 point coord_x, coord_z.
//   rsp returns one Q1.16 noise_value word per evaluate word, in order; load
//   words give nothing on rsp.
//   load all 256 table entries before the first evaluate word.
//   rsp.valid is the valid bit of the last stage; a req word reaches it through
//   the stage registers 1 to 13 in order.
//   throughput: one word per cycle while rsp.ready is high or a stage has a free
//   slot; the 13-stage pipeline moves a word through every enabled stage at once.
//   reset clears all stage valid bits and leaves the table contents untouched.
//   when rsp stalls, the last stage holds its word and the stages behind it keep
//   filling their empty slots; req.ready drops only once every stage is full.
module simplex_noise_2d (
	input  logic        clk,
	input  logic        arst_n,
	snx_in_if.sink      req,
	snx_out_if.source   rsp
);

	localparam int NSTG = snx_pkg::NSTG;
	localparam int TW = snx_pkg::TW;
	localparam int AW = snx_pkg::AW;
	localparam int OW = snx_pkg::OW;
	localparam int F = snx_pkg::FRAC_BITS;
	localparam int SCW = AW + 8;
	localparam logic signed [SCW-1:0] SAT_HI = SCW'(snx_pkg::OUT_MAX);
	localparam logic signed [SCW-1:0] SAT_LO = SCW'(snx_pkg::OUT_MIN);

	snx_pkg::stage_vec_t  vld_q;
	snx_pkg::stage_vec_t  en;
	snx_pkg::pipe_ctl_t   ctl;
	snx_pkg::req_word_t   req_w;
	snx_pkg::front_out_t  fo;

	logic signed [TW-1:0]  term [3];
	logic signed [AW-1:0]  sum_s12;
	logic signed [OW-1:0]  noise_s13;
	logic signed [SCW-1:0] scaled, rnd, vsh;

	// a stage may load when rsp is ready or when it or any stage after it has a free slot
	for (genvar s = 1; s <= NSTG; s++) begin : g_en
		assign en[s] = rsp.ready | ~(&vld_q[NSTG:s]);
	end

	assign ctl.en = en;
	assign ctl.vld = vld_q;
	assign req.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= req.valid;
			end
			for (int s = 2; s <= NSTG; s++) begin
				if (en[s]) begin
					// load words leave the pipe once the table copies are written
					vld_q[s] <= (s == snx_pkg::ST_CORNER) ?
						(vld_q[s-1] & fo.eval) : vld_q[s-1];
				end
			end
		end
	end

	assign req_w.op = req.op;
	assign req_w.idx = req.table_index;
	assign req_w.val = req.table_value;
	assign req_w.x = req.coord_x;
	assign req_w.z = req.coord_z;

	snx_front u_front (
		.clk   (clk),
		.ctl   (ctl),
		.req_w (req_w),
		.fo    (fo)
	);

	for (genvar c = 0; c < 3; c++) begin : g_corner
		snx_corner u_corner (
			.clk  (clk),
			.ctl  (ctl),
			.ci   (fo.c[c]),
			.term (term[c])
		);
	end

	assign scaled = $signed(SCW'(sum_s12)) * $signed(SCW'(7'd70));
	assign rnd = scaled + (SCW'(1) << (F - 1));
	assign vsh = rnd >>> F;

	always_ff @(posedge clk) begin
		if (en[12]) begin
			sum_s12 <= AW'(term[0]) + AW'(term[1]) + AW'(term[2]);
		end
		if (en[13]) begin
			if (vsh > SAT_HI) begin
				noise_s13 <= OW'(snx_pkg::OUT_MAX);
			end else if (vsh < SAT_LO) begin
				noise_s13 <= OW'(snx_pkg::OUT_MIN);
			end else begin
				noise_s13 <= OW'(vsh);
			end
		end
	end

	assign rsp.valid = vld_q[NSTG];
	assign rsp.noise_value = noise_s13;

endmodule

>>> rtl/core/snx_check.sv
// port-level checks for the simplex noise top level, with its bind
// depends on snx_pkg and simplex_noise_2d
module snx_check (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   req_valid,
	input logic                   req_ready,
	input logic                   rsp_valid,
	input logic                   rsp_ready,
	input logic [snx_pkg::OW-1:0] noise_value
);

	// stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(noise_value))
		else $error("rsp word changed while stalled");

	// empty output stage means the pipe can always take a word
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("req stalled with empty output stage");

	// a draining output lets every stage advance
	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ready |-> req_ready)
		else $error("req stalled while rsp drains");

	// no result word out of reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !rsp_valid)
		else $error("rsp valid during reset");

endmodule

bind simplex_noise_2d snx_check u_snx_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.noise_value (rsp.noise_value)
);
